// ===== rtl/spdc_pkg.sv =====
// ----------------------------------------------------------------------------
// spdc_pkg: shared types and constants
// command letters, parser modes, sequencer states and the parser event
// ----------------------------------------------------------------------------
package spdc_pkg;

	// default screen size
	localparam int FB_WIDTH_DEF  = 384;
	localparam int FB_HEIGHT_DEF = 341;

	// coordinate and number widths fixed by the interface
	localparam int COORD_W = 9;
	localparam int NUM_W   = 16;
	localparam int PIX_W   = 8;

	localparam logic [NUM_W-1:0] NUM_MAX    = 16'hFFFF;
	localparam logic [PIX_W-1:0] COLOUR_RST = 8'hFF;

	// command characters
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_R = 8'h52;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_RED,
		MODE_GREEN,
		MODE_BLUE,
		MODE_COUNT
	} mode_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_DOWN,
		DIR_LEFT,
		DIR_RIGHT
	} dir_t;

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_MOVE,
		SQ_RD_ADDR,
		SQ_RD_DATA,
		SQ_EMIT
	} seq_state_t;

	// what one received byte asks of the sequencer
	typedef struct packed {
		logic             clear;
		logic             move;
		dir_t             dir;
		logic [NUM_W-1:0] steps;
	} parse_evt_t;

endpackage

// ===== rtl/spdc_fbmem.sv =====
// ----------------------------------------------------------------------------
// spdc_fbmem: framebuffer memory
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module spdc_fbmem #(
	parameter int DEPTH = spdc_pkg::FB_WIDTH_DEF * spdc_pkg::FB_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [spdc_pkg::PIX_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [spdc_pkg::PIX_W-1:0] rdata
);
	import spdc_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/spdc_parse.sv =====
// ----------------------------------------------------------------------------
// spdc_parse: command byte parser
// decimal accumulation, colour registers and move/clear requests
// ----------------------------------------------------------------------------
module spdc_parse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [7:0]                 rx_byte,
	output spdc_pkg::parse_evt_t       evt,
	output logic [spdc_pkg::PIX_W-1:0] colour
);
	import spdc_pkg::*;

	mode_t              mode_q, mode_d;
	dir_t               dir_q, dir_d;
	logic [NUM_W-1:0]   acc_q, acc_d;
	logic               seen_q, seen_d;
	logic [PIX_W-1:0]   colour_q, colour_d;
	logic               is_digit;
	logic [NUM_W+3:0]   acc_next;

	assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	// acc * 10 + digit, saturating
	assign acc_next = (NUM_W+4)'(acc_q) * (NUM_W+4)'(10) + (NUM_W+4)'(rx_byte[3:0]);

	always_comb begin
		mode_d      = mode_q;
		dir_d       = dir_q;
		acc_d       = acc_q;
		seen_d      = seen_q;
		colour_d    = colour_q;
		evt         = '0;
		evt.dir     = dir_q;
		evt.steps   = acc_q;
		if (take) begin
			if (mode_q != MODE_IDLE) begin
				if (is_digit) begin
					acc_d  = (acc_next > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc_next[NUM_W-1:0];
					seen_d = 1'b1;
				end else if (seen_q) begin
					acc_d  = '0;
					seen_d = 1'b0;
					unique case (mode_q)
						MODE_RED: begin
							colour_d[7:5] = acc_q[3:1];
							mode_d        = MODE_GREEN;
						end
						MODE_GREEN: begin
							colour_d[4:2] = acc_q[3:1];
							mode_d        = MODE_BLUE;
						end
						MODE_BLUE: begin
							colour_d[1:0] = acc_q[3:2];
							mode_d        = MODE_IDLE;
						end
						default: begin
							mode_d   = MODE_IDLE;
							evt.move = 1'b1;
						end
					endcase
				end
			end else begin
				acc_d  = '0;
				seen_d = 1'b0;
				unique case (rx_byte)
					CH_Z: evt.clear = 1'b1;
					CH_C: mode_d = MODE_RED;
					CH_U: begin
						dir_d  = DIR_UP;
						mode_d = MODE_COUNT;
					end
					CH_D: begin
						dir_d  = DIR_DOWN;
						mode_d = MODE_COUNT;
					end
					CH_L: begin
						dir_d  = DIR_LEFT;
						mode_d = MODE_COUNT;
					end
					CH_R: begin
						dir_d  = DIR_RIGHT;
						mode_d = MODE_COUNT;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			dir_q    <= DIR_UP;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			colour_q <= COLOUR_RST;
		end else begin
			mode_q   <= mode_d;
			dir_q    <= dir_d;
			acc_q    <= acc_d;
			seen_q   <= seen_d;
			colour_q <= colour_d;
		end
	end

	assign colour = colour_q;

endmodule

// ===== rtl/serial_pixel_draw_commands.sv =====
// ----------------------------------------------------------------------------
// serial_pixel_draw_commands: serial drawing command interpreter
// parses command bytes and draws into an on-chip 8-bit framebuffer
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   command, rx_byte, read_x, read_y
//  output   out        out_valid / out_stall pixel_value, cursor_col, cursor_row
//
//  order: a plain byte goes from transaction straight to the result, a pixel
//  read through address multiply, memory read, capture and result, a move through
//  its n steps taken (the cycle after the last step closes the move), paced by the
//  single framebuffer write port (one pixel a cycle).
//  'Z' sweeps the whole framebuffer, FB_WIDTH * FB_HEIGHT pixels (130944 by
//  default), one pixel a cycle, before its result.
//  reset: the same clearing sweep runs after reset with in_stall high.
//  stalls: in_stall is high whenever an item is in flight; a result waits in
//  the output register while out_stall is high.
// ----------------------------------------------------------------------------
module serial_pixel_draw_commands #(
	parameter int FB_WIDTH  = spdc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = spdc_pkg::FB_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [7:0]                   rx_byte,
	input  logic [spdc_pkg::COORD_W-1:0] read_x,
	input  logic [spdc_pkg::COORD_W-1:0] read_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [spdc_pkg::PIX_W-1:0]   pixel_value,
	output logic [spdc_pkg::COORD_W-1:0] cursor_col,
	output logic [spdc_pkg::COORD_W-1:0] cursor_row
);
	import spdc_pkg::*;

	localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;
	localparam int AW      = $clog2(FB_SIZE);
	localparam logic [COORD_W-1:0] W_LAST  = COORD_W'(FB_WIDTH - 1);
	localparam logic [COORD_W-1:0] H_LAST  = COORD_W'(FB_HEIGHT - 1);
	localparam logic [COORD_W-1:0] COL_RST = COORD_W'(FB_WIDTH / 2);
	localparam logic [COORD_W-1:0] ROW_RST = COORD_W'(FB_HEIGHT / 2);
	localparam logic [AW-1:0] ADDR_RST = AW'((FB_HEIGHT / 2) * FB_WIDTH + FB_WIDTH / 2);
	localparam logic [AW-1:0] ADDR_LAST = AW'(FB_SIZE - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(FB_WIDTH);

	seq_state_t state_q, state_d;

	// parser
	parse_evt_t       evt;
	logic [PIX_W-1:0] colour;
	logic             accept;

	// cursor and move sequencing
	logic [COORD_W-1:0] col_q, row_q;
	logic [AW-1:0]      cur_addr_q;
	logic [NUM_W-1:0]   steps_q;
	dir_t               mv_dir_q;
	logic               at_edge;
	logic               step_go;
	logic [COORD_W-1:0] col_nxt, row_nxt;
	logic [AW-1:0]      addr_nxt;

	// clearing sweep
	logic [AW-1:0] clr_addr_q;
	logic          clr_item_q;
	logic          clr_last;

	// pixel read path
	logic [AW-1:0]    rd_addr_c;
	logic [AW-1:0]    rd_addr_s1;
	logic             rd_in_range_c;
	logic             rd_in_range_s1;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] pix_q;

	// framebuffer ports
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PIX_W-1:0] mem_wdata;
	logic             mem_re;

	// output register
	logic               out_valid_q;
	logic               out_load;
	logic [PIX_W-1:0]   pix_out_q;
	logic [COORD_W-1:0] col_out_q, row_out_q;

	assign in_stall = (state_q != SQ_IDLE);
	assign accept   = in_valid && !in_stall;

	spdc_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (accept && !command),
		.rx_byte (rx_byte),
		.evt     (evt),
		.colour  (colour)
	);

	// edge test and next cursor position for one step
	always_comb begin
		col_nxt  = col_q;
		row_nxt  = row_q;
		addr_nxt = cur_addr_q;
		at_edge  = 1'b0;
		unique case (mv_dir_q)
			DIR_UP: begin
				at_edge  = (row_q == '0);
				row_nxt  = row_q - COORD_W'(1);
				addr_nxt = cur_addr_q - ROW_STEP;
			end
			DIR_DOWN: begin
				at_edge  = (row_q == H_LAST);
				row_nxt  = row_q + COORD_W'(1);
				addr_nxt = cur_addr_q + ROW_STEP;
			end
			DIR_LEFT: begin
				at_edge  = (col_q == '0);
				col_nxt  = col_q - COORD_W'(1);
				addr_nxt = cur_addr_q - AW'(1);
			end
			default: begin
				at_edge  = (col_q == W_LAST);
				col_nxt  = col_q + COORD_W'(1);
				addr_nxt = cur_addr_q + AW'(1);
			end
		endcase
	end

	assign step_go  = (state_q == SQ_MOVE) && (steps_q != '0) && !at_edge;
	assign clr_last = (clr_addr_q == ADDR_LAST);
	assign out_load = (state_q == SQ_EMIT) && (!out_valid_q || !out_stall);

	// read address: one constant multiply, registered before the memory
	assign rd_in_range_c = (read_x < COORD_W'(FB_WIDTH)) && (read_y < COORD_W'(FB_HEIGHT));
	assign rd_addr_c     = rd_in_range_c ?
		(AW'(read_y) * ROW_STEP + AW'(read_x)) : '0;

	// framebuffer access
	assign mem_we    = (state_q == SQ_CLEAR) || step_go;
	assign mem_waddr = (state_q == SQ_CLEAR) ? clr_addr_q : addr_nxt;
	assign mem_wdata = (state_q == SQ_CLEAR) ? '0 : colour;
	assign mem_re    = (state_q == SQ_RD_ADDR);

	spdc_fbmem #(
		.DEPTH (FB_SIZE),
		.AW    (AW)
	) u_fbmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_addr_s1),
		.rdata (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_CLEAR: begin
				if (clr_last) begin
					state_d = clr_item_q ? SQ_EMIT : SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (accept) begin
					if (command) begin
						state_d = SQ_RD_ADDR;
					end else if (evt.clear) begin
						state_d = SQ_CLEAR;
					end else if (evt.move) begin
						state_d = SQ_MOVE;
					end else begin
						state_d = SQ_EMIT;
					end
				end
			end
			SQ_MOVE: begin
				if (!step_go) begin
					state_d = SQ_EMIT;
				end
			end
			SQ_RD_ADDR: state_d = SQ_RD_DATA;
			SQ_RD_DATA: state_d = SQ_EMIT;
			SQ_EMIT: begin
				if (out_load) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// cursor, sweep and move control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= COL_RST;
			row_q      <= ROW_RST;
			cur_addr_q <= ADDR_RST;
			steps_q    <= '0;
			mv_dir_q   <= DIR_UP;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
		end else begin
			if (accept && !command) begin
				steps_q  <= evt.steps;
				mv_dir_q <= evt.dir;
			end
			if (accept && !command && evt.clear) begin
				clr_addr_q <= '0;
				clr_item_q <= 1'b1;
			end else if (state_q == SQ_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_last) begin
					clr_item_q <= 1'b0;
				end
			end
			if (step_go) begin
				col_q      <= col_nxt;
				row_q      <= row_nxt;
				cur_addr_q <= addr_nxt;
				steps_q    <= steps_q - NUM_W'(1);
			end
		end
	end

	// read pipeline and pixel result, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_s1     <= rd_addr_c;
			rd_in_range_s1 <= rd_in_range_c;
			pix_q          <= '0;
		end else if (state_q == SQ_RD_DATA) begin
			pix_q <= rd_in_range_s1 ? rd_data : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_out_q <= pix_q;
			col_out_q <= col_q;
			row_out_q <= row_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pix_out_q;
	assign cursor_col  = col_out_q;
	assign cursor_row  = row_out_q;

`ifndef NO_ASSERTIONS
	// incremental cursor address must follow the coordinates
	a_addr_track: assert property (@(posedge clk) disable iff (!arst_n)
		cur_addr_q == AW'(32'(row_q) * FB_WIDTH + 32'(col_q)))
		else $error("cursor address out of step with cursor");

	// the cursor never leaves the screen
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= W_LAST) && (row_q <= H_LAST))
		else $error("cursor off screen");

	// a pixel read transaction reaches the memory in the next cycle
	a_read_issue: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command |=> mem_re && !mem_we)
		else $error("pixel read not issued");

	// a finished result held back by out_stall is not dropped
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_EMIT) && out_valid_q && out_stall |=> state_q == SQ_EMIT)
		else $error("result dropped while output stalled");

	// the sweep stays inside the framebuffer
	a_clear_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_CLEAR) |-> clr_addr_q <= ADDR_LAST)
		else $error("clear sweep out of range");
`endif

endmodule
